// File: hdl/srte_pkg.sv
// Shared types and constants for the serial request transaction engine.
// No dependencies; imported by every module of the block.
package srte_pkg;

    localparam int BUDGET_BITS = 15;

    localparam logic [7:0] ACK_READ        = 8'h80;
    localparam logic [7:0] ACK_OK          = 8'h00;
    localparam logic [7:0] CHUNK_SIZE_INIT = 8'd16;

    // Item kinds carried in tuser
    localparam logic [2:0] OP_START_READ  = 3'd0;
    localparam logic [2:0] OP_START_WRITE = 3'd1;
    localparam logic [2:0] OP_LINE_BYTE   = 3'd2;
    localparam logic [2:0] OP_HOST_BYTE   = 3'd3;
    localparam logic [2:0] OP_TICK        = 3'd4;

    localparam logic [1:0] OUTCOME_NONE = 2'd0;
    localparam logic [1:0] OUTCOME_OK   = 2'd1;
    localparam logic [1:0] OUTCOME_FAIL = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE           = 3'd0,
        PH_WAIT_ACK       = 3'd1,
        PH_WAIT_SIZE      = 3'd2,
        PH_READ_DATA      = 3'd3,
        PH_WRITE_DATA     = 3'd4,
        PH_WAIT_CHUNK_ACK = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  request_code;
        logic [7:0]  length;
        logic [14:0] time_budget;
        logic [7:0]  payload;
    } item_t;

    typedef struct packed {
        logic       line_send;
        logic [7:0] line_byte;
        logic       host_deliver;
        logic [7:0] host_byte;
        logic       need_data;
        logic       busy_res;
        logic [1:0] outcome;
    } result_t;

endpackage

// File: hdl/srte_in_reg.sv
// Input register stage of the serial request transaction engine.
// Depends on srte_pkg for the item type.
module srte_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  srte_pkg::item_t item_in,
    input  logic          pop,
    output logic          ready,
    output logic          valid,
    output srte_pkg::item_t item_out
);
    import srte_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign ready    = !valid_reg || pop;
    assign valid    = valid_reg;
    assign item_out = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load && ready) begin
            valid_reg <= 1'b1;
        end else if (pop) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && ready) begin
            item_reg <= item_in;
        end
    end

endmodule

// File: hdl/srte_core.sv
// Protocol state machine and counters of the serial request transaction engine.
// Depends on srte_pkg for phases, codes and item/result types.
module srte_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  srte_pkg::item_t item,
    input  logic [7:0]      chunk_size,
    output srte_pkg::result_t result
);
    import srte_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic                   is_write_reg, is_write_next;
    logic [7:0]             expected_length_reg, expected_length_next;
    logic [7:0]             bytes_left_reg, bytes_left_next;
    logic [7:0]             chunk_count_reg, chunk_count_next;
    logic [BUDGET_BITS-1:0] budget_left_reg, budget_left_next;

    logic       waiting_line;
    logic [7:0] bytes_dec;
    logic [7:0] count_inc;
    logic       chunk_full;

    assign waiting_line = (phase_reg == PH_WAIT_ACK) || (phase_reg == PH_WAIT_SIZE) ||
                          (phase_reg == PH_READ_DATA) || (phase_reg == PH_WAIT_CHUNK_ACK);
    assign bytes_dec  = bytes_left_reg - 8'd1;
    assign count_inc  = chunk_count_reg + 8'd1;
    assign chunk_full = (count_inc == chunk_size);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (item.operation) inside
            OP_START_READ, OP_START_WRITE: begin
                phase_next = PH_WAIT_ACK;
            end
            OP_LINE_BYTE: begin
                unique case (phase_reg)
                    PH_WAIT_ACK: begin
                        if (is_write_reg) begin
                            if (item.payload != ACK_OK) begin
                                phase_next = PH_IDLE;
                            end else if (bytes_left_reg == 8'd0) begin
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_WRITE_DATA;
                            end
                        end else if (item.payload == ACK_READ) begin
                            phase_next = PH_WAIT_SIZE;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WAIT_SIZE: begin
                        if (item.payload != expected_length_reg) begin
                            phase_next = PH_IDLE;
                        end else if (bytes_left_reg == 8'd0) begin
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_READ_DATA;
                        end
                    end
                    PH_READ_DATA: begin
                        if (bytes_dec == 8'd0) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WAIT_CHUNK_ACK: begin
                        phase_next = (item.payload == ACK_OK) ? PH_WRITE_DATA : PH_IDLE;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            OP_HOST_BYTE: begin
                if (phase_reg == PH_WRITE_DATA) begin
                    if (bytes_dec == 8'd0) begin
                        phase_next = PH_IDLE;
                    end else if (chunk_full) begin
                        phase_next = PH_WAIT_CHUNK_ACK;
                    end
                end
            end
            OP_TICK: begin
                if (waiting_line && budget_left_reg == '0) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Outputs and counters
    always_comb begin
        is_write_next        = is_write_reg;
        expected_length_next = expected_length_reg;
        bytes_left_next      = bytes_left_reg;
        chunk_count_next     = chunk_count_reg;
        budget_left_next     = budget_left_reg;
        result               = '0;
        unique case (item.operation) inside
            OP_START_READ, OP_START_WRITE: begin
                is_write_next        = (item.operation == OP_START_WRITE);
                expected_length_next = item.length;
                bytes_left_next      = item.length;
                chunk_count_next     = 8'd0;
                budget_left_next     = BUDGET_BITS'(item.time_budget);
                result.line_send     = 1'b1;
                result.line_byte     = item.request_code;
            end
            OP_LINE_BYTE: begin
                unique case (phase_reg)
                    PH_WAIT_ACK: begin
                        if (is_write_reg) begin
                            if (item.payload == ACK_OK) begin
                                result.line_send = 1'b1;
                                result.line_byte = expected_length_reg;
                                if (bytes_left_reg == 8'd0) begin
                                    result.outcome = OUTCOME_OK;
                                end
                            end else begin
                                result.outcome = OUTCOME_FAIL;
                            end
                        end else if (item.payload != ACK_READ) begin
                            result.outcome = OUTCOME_FAIL;
                        end
                    end
                    PH_WAIT_SIZE: begin
                        if (item.payload != expected_length_reg) begin
                            result.outcome = OUTCOME_FAIL;
                        end else if (bytes_left_reg == 8'd0) begin
                            result.outcome = OUTCOME_OK;
                        end
                    end
                    PH_READ_DATA: begin
                        result.host_deliver = 1'b1;
                        result.host_byte    = item.payload;
                        bytes_left_next     = bytes_dec;
                        chunk_count_next    = count_inc;
                        if (bytes_dec == 8'd0) begin
                            result.outcome = OUTCOME_OK;
                        end else if (chunk_full) begin
                            chunk_count_next = 8'd0;
                            result.line_send = 1'b1;
                            result.line_byte = ACK_OK;
                        end
                    end
                    PH_WAIT_CHUNK_ACK: begin
                        if (item.payload != ACK_OK) begin
                            result.outcome = OUTCOME_FAIL;
                        end
                    end
                    default: begin
                        result.outcome = OUTCOME_NONE;
                    end
                endcase
            end
            OP_HOST_BYTE: begin
                if (phase_reg == PH_WRITE_DATA) begin
                    result.line_send = 1'b1;
                    result.line_byte = item.payload;
                    bytes_left_next  = bytes_dec;
                    chunk_count_next = count_inc;
                    if (bytes_dec == 8'd0) begin
                        result.outcome = OUTCOME_OK;
                    end else if (chunk_full) begin
                        chunk_count_next = 8'd0;
                    end
                end
            end
            OP_TICK: begin
                if (waiting_line) begin
                    if (budget_left_reg == '0) begin
                        result.outcome = OUTCOME_FAIL;
                    end else begin
                        budget_left_next = budget_left_reg - 1'b1;
                    end
                end
            end
            default: begin
                result.outcome = OUTCOME_NONE;
            end
        endcase
        result.need_data = (phase_next == PH_WRITE_DATA);
        result.busy_res  = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            is_write_reg        <= 1'b0;
            expected_length_reg <= 8'd0;
            bytes_left_reg      <= 8'd0;
            chunk_count_reg     <= 8'd0;
            budget_left_reg     <= '0;
        end else if (step) begin
            phase_reg           <= phase_next;
            is_write_reg        <= is_write_next;
            expected_length_reg <= expected_length_next;
            bytes_left_reg      <= bytes_left_next;
            chunk_count_reg     <= chunk_count_next;
            budget_left_reg     <= budget_left_next;
        end
    end

endmodule

// File: hdl/serial_request_transaction_engine.sv
// Top level of the serial request transaction engine: stream ports, chunk size
// register, input stage, protocol core and result register.
// Depends on srte_pkg, srte_in_reg and srte_core.
//
// Usage: each slave-side transaction is one event for the requester: a start
// of a read or write (request code, length, tick budget), a byte received from
// the line, a host data byte to send, or a timer tick. s_tuser says which.
// Every accepted event yields exactly one master-side transaction carrying a
// byte to transmit on the line (if any), a byte for the host (if any), the
// need_data and busy flags, and the outcome (ok or failed on the ending event).
// The chunk size register is written over the cfg_valid/cfg_ready channel,
// which is always ready; write it only while the engine is idle.
// A result appears on m_ after its event is accepted: the event sits in the input
// register until the result register is free or being drained, and is then stored
// there. Throughput: one event per cycle while m_tready stays high, set by the
// single-pass update of the protocol state between those two registers.
// Reset (aresetn low, synchronous): phase idle, counters and budget cleared,
// chunk size back to 16, both stages empty.
// Stall: while m_tready is low the result register holds its transaction; one
// further event waits in the input register, after which s_tready drops.
module serial_request_transaction_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // Event channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] request_code, [15:8] length, [30:16] time_budget, [38:31] payload, [39] unused
    input  logic [39:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] line_send, [8:1] line_byte, [9] host_deliver, [17:10] host_byte,
    // [18] need_data, [19] busy_res, [21:20] outcome, [23:22] zero
    output logic [23:0] m_tdata,
    // Chunk size register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import srte_pkg::*;

    item_t   s_item;
    item_t   held_item;
    logic    held_valid;
    logic    step;
    result_t step_result;

    logic    out_valid_reg;
    result_t out_reg;
    logic [7:0] chunk_size_reg;

    // Unpack the slave-side transaction
    assign s_item.operation    = s_tuser;
    assign s_item.request_code = s_tdata[7:0];
    assign s_item.length       = s_tdata[15:8];
    assign s_item.time_budget  = s_tdata[30:16];
    assign s_item.payload      = s_tdata[38:31];

    // Advance an event whenever the result register is free or being drained
    assign step = held_valid && (!out_valid_reg || m_tready);

    srte_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_tvalid),
        .item_in  (s_item),
        .pop      (step),
        .ready    (s_tready),
        .valid    (held_valid),
        .item_out (held_item)
    );

    srte_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (held_item),
        .chunk_size (chunk_size_reg),
        .result     (step_result)
    );

    // Chunk size register; the channel never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= CHUNK_SIZE_INIT;
        end else if (cfg_valid && cfg_ready) begin
            chunk_size_reg <= cfg_data;
        end
    end

    // Result register: hold while stalled, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_reg.outcome,
                       out_reg.busy_res,
                       out_reg.need_data,
                       out_reg.host_byte,
                       out_reg.host_deliver,
                       out_reg.line_byte,
                       out_reg.line_send};

endmodule
